// File: design/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg - shared types and constants of the linear interpolation resampler
// Field widths, register codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lir_pkg;

  // Fixed field and register widths
  localparam int SMP_W     = 16;
  localparam int CFG_W     = 21;
  localparam int CNT_W     = 21;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // Outputs per input request are capped; the counter must hold the cap itself
  localparam int MAX_OUT   = 40;
  localparam int OUTCNT_W  = $clog2(MAX_OUT + 1);

  // Default geometry
  localparam int DEF_INDEX_WIDTH = 20;
  localparam int DEF_FRAC_BITS   = 16;

  // Register reset values: 1.0 in Q16
  localparam logic [CFG_W-1:0] STEP_RESET = CFG_W'(65536);
  localparam logic [CFG_W-1:0] OPI_RESET  = CFG_W'(65536);

  // Register select (word index within the port)
  localparam logic REG_STEP = 1'b0;
  localparam logic REG_OPI  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TMUL,
    ST_TRND,
    ST_EVAL,
    ST_MUL,
    ST_OUT
  } lir_state_t;

  // Controller to datapath
  typedef struct packed {
    logic take_in;     // latch the incoming request
    logic tgt_mul;     // form n_in * out_per_in
    logic tgt_rnd;     // round the product into the output target
    logic load_op;     // load interpolation operands, advance position
    logic use_lerp;    // interpolate, else pass the current sample
    logic mul;         // multiply difference by fraction
    logic put_out;     // load the output register
    logic out_final;   // mark the loaded output as last
    logic end_item;    // commit a non-last request
    logic clear_clip;  // drop all clip state after the last request
  } lir_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic have_prev;
    logic last;
    logic lt_limit;     // position below the current sample index
    logic below_tgt;    // outputs emitted still below the target
    logic next_at_tgt;  // one more output reaches the target
    logic out_free;     // output register can take a value this cycle
  } lir_sts_t;

endpackage

// File: design/lir_ctrl.sv
// ----------------------------------------------------------------------------
// lir_ctrl - sequencer of the linear interpolation resampler
// Takes one input request at a time, walks the output loop through the evaluate,
// multiply and output states and issues commands to the datapath.
// ----------------------------------------------------------------------------
module lir_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  lir_pkg::lir_sts_t sts,
  output lir_pkg::lir_cmd_t cmd
);

  lir_pkg::lir_state_t               state_r, state_nxt;
  logic [lir_pkg::OUTCNT_W-1:0]      count_r, count_nxt;
  logic                              final_r, final_nxt;
  logic                              at_cap;
  logic                              emit;
  logic                              is_final;

  // Hold state, per-request output count and the last-output mark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lir_pkg::ST_IDLE;
      count_r <= '0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      final_r <= final_nxt;
    end
  end

  assign at_cap = (count_r == lir_pkg::OUTCNT_W'(lir_pkg::MAX_OUT));

  // Decide whether the loop emits another output
  always_comb begin
    if (sts.last) begin
      emit     = !at_cap && (sts.below_tgt || (count_r == '0));
      is_final = (count_r == lir_pkg::OUTCNT_W'(lir_pkg::MAX_OUT - 1)) || sts.next_at_tgt;
    end else begin
      emit     = sts.have_prev && sts.lt_limit && !at_cap;
      is_final = 1'b0;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    final_nxt = final_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      lir_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          count_nxt   = '0;
          state_nxt   = in_last ? lir_pkg::ST_TMUL : lir_pkg::ST_EVAL;
        end
      end
      lir_pkg::ST_TMUL: begin
        cmd.tgt_mul = 1'b1;
        state_nxt   = lir_pkg::ST_TRND;
      end
      lir_pkg::ST_TRND: begin
        cmd.tgt_rnd = 1'b1;
        state_nxt   = lir_pkg::ST_EVAL;
      end
      lir_pkg::ST_EVAL: begin
        if (emit) begin
          cmd.load_op  = 1'b1;
          cmd.use_lerp = sts.have_prev && sts.lt_limit;
          count_nxt    = count_r + lir_pkg::OUTCNT_W'(1);
          final_nxt    = is_final;
          state_nxt    = lir_pkg::ST_MUL;
        end else begin
          cmd.clear_clip = sts.last;
          cmd.end_item   = !sts.last;
          state_nxt      = lir_pkg::ST_IDLE;
        end
      end
      lir_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = lir_pkg::ST_OUT;
      end
      lir_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.put_out   = 1'b1;
          cmd.out_final = final_r;
          state_nxt     = lir_pkg::ST_EVAL;
        end
      end
      default: begin
        state_nxt = lir_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/lir_dp.sv
// ----------------------------------------------------------------------------
// lir_dp - datapath of the linear interpolation resampler
// Clip state, output target, interpolation multiplier and the output register.
// ----------------------------------------------------------------------------
module lir_dp #(
  parameter int INDEX_WIDTH = lir_pkg::DEF_INDEX_WIDTH,
  parameter int FRAC_BITS   = lir_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [lir_pkg::SMP_W-1:0]    in_sample,
  input  logic                                in_last,
  input  logic        [lir_pkg::CFG_W-1:0]    step_q16,
  input  logic        [lir_pkg::CFG_W-1:0]    out_per_in_q16,
  input  lir_pkg::lir_cmd_t                   cmd,
  output lir_pkg::lir_sts_t                   sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lir_pkg::SMP_W-1:0]    out_sample,
  output logic                                out_last
);

  localparam int SW     = lir_pkg::SMP_W;
  localparam int PH_W   = INDEX_WIDTH + FRAC_BITS;
  localparam int PS_W   = ((PH_W > lir_pkg::CFG_W) ? PH_W : lir_pkg::CFG_W) + 1;
  localparam int TP_W   = INDEX_WIDTH + 1 + lir_pkg::CFG_W;
  localparam int TS_W   = TP_W + 1;
  localparam int TGT_W  = TS_W - FRAC_BITS;
  localparam int CMP_W  = (TGT_W > lir_pkg::CNT_W) ? TGT_W : lir_pkg::CNT_W;
  localparam int MP_W   = SW + 1 + FRAC_BITS + 1;
  localparam int ACC_W  = MP_W + 1;

  // Clip state
  logic signed [SW-1:0]            prev_r, prev_nxt;
  logic                            have_prev_r, have_prev_nxt;
  logic [INDEX_WIDTH-1:0]          index_r, index_nxt;
  logic [PH_W-1:0]                 phase_r, phase_nxt;
  logic [lir_pkg::CNT_W-1:0]       emitted_r, emitted_nxt;
  // Request and arithmetic payload
  logic signed [SW-1:0]            cur_r, cur_nxt;
  logic                            last_r, last_nxt;
  logic [TP_W-1:0]                 tprod_r, tprod_nxt;
  logic [TGT_W-1:0]                target_r, target_nxt;
  logic signed [SW-1:0]            s0_r, s0_nxt;
  logic signed [SW:0]              diff_r, diff_nxt;
  logic [FRAC_BITS-1:0]            frac_r, frac_nxt;
  logic signed [MP_W-1:0]          mprod_r, mprod_nxt;
  // Output register
  logic                            out_valid_r, out_valid_nxt;
  logic signed [SW-1:0]            out_sample_r, out_sample_nxt;
  logic                            out_last_r, out_last_nxt;

  logic [PH_W-1:0]                 limit;
  logic [PS_W-1:0]                 phase_sum;
  logic [lir_pkg::CNT_W-1:0]       emitted_inc;
  logic [INDEX_WIDTH:0]            n_in;
  logic [TS_W-1:0]                 tsum;
  logic [TGT_W-1:0]                tgt_raw;
  logic signed [ACC_W-1:0]         acc;
  logic signed [ACC_W-1:0]         quo;
  logic signed [ACC_W-1:0]         quo_tz;

  // Position of the current input sample and saturating advances
  assign limit       = {index_r, {FRAC_BITS{1'b0}}};
  assign phase_sum   = PS_W'(phase_r) + PS_W'(step_q16);
  assign emitted_inc = (&emitted_r) ? emitted_r : emitted_r + lir_pkg::CNT_W'(1);
  assign n_in        = {1'b0, index_r} + (INDEX_WIDTH+1)'(1);

  // Round n_in * out_per_in to an output count, at least one
  assign tsum    = {1'b0, tprod_r} + (TS_W'(1) << (FRAC_BITS - 1));
  assign tgt_raw = tsum[TS_W-1:FRAC_BITS];

  // s0 * 2^F + (s1 - s0) * f, divided by 2^F with truncation toward zero
  assign acc    = (ACC_W'(s0_r) <<< FRAC_BITS) + ACC_W'(mprod_r);
  assign quo    = acc >>> FRAC_BITS;
  assign quo_tz = quo + ACC_W'(acc[ACC_W-1] && (|acc[FRAC_BITS-1:0]));

  // Status towards the controller
  assign sts.have_prev   = have_prev_r;
  assign sts.last        = last_r;
  assign sts.lt_limit    = (phase_r < limit);
  assign sts.below_tgt   = (CMP_W'(emitted_r) < CMP_W'(target_r));
  assign sts.next_at_tgt = (CMP_W'(emitted_inc) >= CMP_W'(target_r));
  assign sts.out_free    = !out_valid_r || out_ready;

  always_comb begin
    prev_nxt       = prev_r;
    have_prev_nxt  = have_prev_r;
    index_nxt      = index_r;
    phase_nxt      = phase_r;
    emitted_nxt    = emitted_r;
    cur_nxt        = cur_r;
    last_nxt       = last_r;
    tprod_nxt      = tprod_r;
    target_nxt     = target_r;
    s0_nxt         = s0_r;
    diff_nxt       = diff_r;
    frac_nxt       = frac_r;
    mprod_nxt      = mprod_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;

    // Latch the request
    if (cmd.take_in) begin
      cur_nxt  = in_sample;
      last_nxt = in_last;
    end
    // Output target for the last request
    if (cmd.tgt_mul) begin
      tprod_nxt = TP_W'(n_in) * TP_W'(out_per_in_q16);
    end
    if (cmd.tgt_rnd) begin
      target_nxt = (tgt_raw == '0) ? TGT_W'(1) : tgt_raw;
    end
    // Load operands and advance position and output count
    if (cmd.load_op) begin
      if (cmd.use_lerp) begin
        s0_nxt   = prev_r;
        diff_nxt = (SW+1)'(cur_r) - (SW+1)'(prev_r);
      end else begin
        s0_nxt   = cur_r;
        diff_nxt = '0;
      end
      frac_nxt    = phase_r[FRAC_BITS-1:0];
      phase_nxt   = (|phase_sum[PS_W-1:PH_W]) ? {PH_W{1'b1}} : phase_sum[PH_W-1:0];
      emitted_nxt = emitted_inc;
    end
    if (cmd.mul) begin
      mprod_nxt = MP_W'(diff_r) * $signed({1'b0, frac_r});
    end
    // Load the output register
    if (cmd.put_out) begin
      out_valid_nxt  = 1'b1;
      out_sample_nxt = quo_tz[SW-1:0];
      out_last_nxt   = cmd.out_final;
    end
    // Commit a non-last request
    if (cmd.end_item) begin
      prev_nxt      = cur_r;
      have_prev_nxt = 1'b1;
      index_nxt     = (&index_r) ? index_r : index_r + INDEX_WIDTH'(1);
    end
    // Drop the clip after its last request
    if (cmd.clear_clip) begin
      prev_nxt      = '0;
      have_prev_nxt = 1'b0;
      index_nxt     = '0;
      phase_nxt     = '0;
      emitted_nxt   = '0;
    end
  end

  // Control state and clip state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      index_r     <= '0;
      phase_r     <= '0;
      emitted_r   <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      index_r     <= index_nxt;
      phase_r     <= phase_nxt;
      emitted_r   <= emitted_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    tprod_r      <= tprod_nxt;
    target_r     <= target_nxt;
    s0_r         <= s0_nxt;
    diff_r       <= diff_nxt;
    frac_r       <= frac_nxt;
    mprod_r      <= mprod_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

endmodule

// File: design/linear_interp_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler - linear interpolation sample rate converter
// Resamples a clip of signed 16-bit mono samples by a Q16 phase step and
// emits the tail up to the rounded output count on the clip's last sample.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_sample, in_last
//   out      output     out_valid / out_ready out_sample, out_last
//   cfg      input      psel/penable/pready   paddr, pwdata, pwrite, prdata
//
// Each output passes the evaluate, multiply and output steps; the last request
// first runs the output-count multiply and rounding steps.
// Each output goes through the single interpolation multiplier.
// in_ready is high only while the sequencer is idle; the output register lets
// the next request enter while the last result still waits.
// A low out_ready stretches the output step; no more than 40 outputs follow
// one request. Reset (rst_n low, synchronous) clears the clip and sets both
// registers to 1.0.
// ----------------------------------------------------------------------------
module linear_interp_resampler #(
  parameter int INDEX_WIDTH = lir_pkg::DEF_INDEX_WIDTH,
  parameter int FRAC_BITS   = lir_pkg::DEF_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [lir_pkg::SMP_W-1:0]     in_sample,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [lir_pkg::SMP_W-1:0]     out_sample,
  output logic                                 out_last,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [lir_pkg::PADDR_W-1:0]   paddr,
  input  logic        [lir_pkg::PDATA_W-1:0]   pwdata,
  output logic        [lir_pkg::PDATA_W-1:0]   prdata,
  output logic                                 pready
);

  logic [lir_pkg::CFG_W-1:0] step_r, step_nxt;
  logic [lir_pkg::CFG_W-1:0] opi_r, opi_nxt;
  logic                      wr_en;
  lir_pkg::lir_cmd_t         cmd;
  lir_pkg::lir_sts_t         sts;

  // Register port: write in the access phase, read back by word index
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    step_nxt = step_r;
    opi_nxt  = opi_r;
    if (wr_en) begin
      case (paddr[2])
        lir_pkg::REG_STEP: step_nxt = pwdata[lir_pkg::CFG_W-1:0];
        lir_pkg::REG_OPI:  opi_nxt  = pwdata[lir_pkg::CFG_W-1:0];
        default: begin
          step_nxt = step_r;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      lir_pkg::REG_STEP: prdata = lir_pkg::PDATA_W'(step_r);
      lir_pkg::REG_OPI:  prdata = lir_pkg::PDATA_W'(opi_r);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= lir_pkg::STEP_RESET;
      opi_r  <= lir_pkg::OPI_RESET;
    end else begin
      step_r <= step_nxt;
      opi_r  <= opi_nxt;
    end
  end

  lir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lir_dp #(
    .INDEX_WIDTH (INDEX_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_sample      (in_sample),
    .in_last        (in_last),
    .step_q16       (step_r),
    .out_per_in_q16 (opi_r),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample     (out_sample),
    .out_last       (out_last)
  );

endmodule

// File: design/lir_chk.sv
// ----------------------------------------------------------------------------
// lir_chk - port checker for the linear interpolation resampler
// Watches the top level's channels and register port; bound to the top level.
// ----------------------------------------------------------------------------
module lir_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic signed [lir_pkg::SMP_W-1:0]    in_sample,
  input logic                                in_last,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [lir_pkg::SMP_W-1:0]    out_sample,
  input logic                                out_last,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic        [lir_pkg::PADDR_W-1:0]  paddr,
  input logic        [lir_pkg::PDATA_W-1:0]  pwdata,
  input logic        [lir_pkg::PDATA_W-1:0]  prdata,
  input logic                                pready
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_last))
    else $error("stalled result changed");

  // One request at a time: the sequencer leaves idle after taking one
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken in consecutive cycles");

  // A step write reads back masked to the register width
  a_step_rb: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && (paddr[2] == lir_pkg::REG_STEP)
    |=> (paddr[2] != lir_pkg::REG_STEP) ||
        (prdata == lir_pkg::PDATA_W'($past(pwdata[lir_pkg::CFG_W-1:0]))))
    else $error("step register read-back mismatch");

  // The register port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind linear_interp_resampler lir_chk u_lir_chk (.*);
